// ===== sv/fpvl_pkg.sv =====
package fpvl_pkg;

  // Width of one stored half-word and of the emitted slot index
  localparam int unsigned VALUE_W      = 16;
  localparam int unsigned SLOT_INDEX_W = 6;

  // Content of an erased flash half-word
  localparam logic [VALUE_W-1:0] ERASED_WORD = 16'hFFFF;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SET    = 2'd1,
    OP_UPDATE = 2'd2
  } op_t;

endpackage

// ===== sv/fpvl_page_ram.sv =====
module fpvl_page_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [fpvl_pkg::VALUE_W-1:0]     wdata,
  input  logic [AW-1:0]                    raddr,
  output logic [fpvl_pkg::VALUE_W-1:0]     rdata
);

  logic [fpvl_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [fpvl_pkg::VALUE_W-1:0] rdata_r;

  // Write one slot
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/flash_page_value_log.sv =====
// Keeps one 16-bit setting as an append log over a page of SLOT_COUNT slots.
// Input: a word is taken at a clock edge with start high and busy low.
//   in_operation load: store in_word_value at the next load slot; in_load_last
//   (or the last slot) ends the start-up load. An empty page takes
//   the default value into slot 0 and marks a commit pending.
//   in_operation set: replace the held value. update: append the held value
//   if it changed, wrapping to slot 0 with an erase request on a full page,
//   then emit the page image if a commit is pending. Code 3 is dropped.
// Load and set words never raise busy.
// An update with a commit pending holds busy while the page memory is
// swept one slot per cycle through its single read port; the page words
// leave on the out_ ports one per cycle, marked by out_strobe, the first
// one once slot 0 has passed the read register and the emit stage, out_last
// on the final one. An update with nothing pending produces no word.
// The receiver cannot stall: each word is present for exactly one cycle.
// The default takes cfg_wdata at any edge with cfg_we high (while idle).
// Synchronous reset clears pointer, held and committed values, flags and the
// default; page memory contents stay undefined until written.
module flash_page_value_log #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_operation,
  input  logic [fpvl_pkg::VALUE_W-1:0]          in_word_value,
  input  logic                                  in_load_last,
  input  logic                                  cfg_we,
  input  logic [fpvl_pkg::VALUE_W-1:0]          cfg_wdata,
  output logic                                  out_strobe,
  output logic                                  out_erase_first,
  output logic [fpvl_pkg::SLOT_INDEX_W-1:0]     out_slot_index,
  output logic [fpvl_pkg::VALUE_W-1:0]          out_slot_data,
  output logic [fpvl_pkg::VALUE_W-1:0]          out_current_value,
  output logic                                  out_last
);

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned PW = $clog2(SLOT_COUNT + 1);
  localparam logic [AW-1:0] LAST_K = AW'(SLOT_COUNT - 1);
  localparam logic [PW-1:0] FULL_P = PW'(SLOT_COUNT);

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

  state_t                         state_r;
  logic [PW-1:0]                  ptr_r;
  logic [fpvl_pkg::VALUE_W-1:0]   held_r;
  logic [fpvl_pkg::VALUE_W-1:0]   committed_r;
  logic                           pending_r;
  logic                           erase_r;
  logic [AW-1:0]                  load_pos_r;
  logic                           found_r;
  logic [fpvl_pkg::VALUE_W-1:0]   default_r;
  logic [AW-1:0]                  rd_k_r;

  // Emit stage, aligned with the memory read data
  logic                           emit_valid_r;
  logic [AW-1:0]                  emit_k_r;
  logic                           emit_in_r;
  logic                           emit_erase_r;
  logic                           emit_last_r;

  logic                           accept;
  fpvl_pkg::op_t                  op;
  logic                           word_written;
  logic                           found_nxt;
  logic                           load_end;
  logic                           changed;
  logic                           wrap;
  logic                           pending_nxt;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [fpvl_pkg::VALUE_W-1:0]   ram_wdata;
  logic [fpvl_pkg::VALUE_W-1:0]   ram_rdata;

  assign busy         = (state_r == ST_STREAM);
  assign accept       = start && !busy;
  assign op           = fpvl_pkg::op_t'(in_operation);
  assign word_written = (in_word_value != fpvl_pkg::ERASED_WORD);
  assign found_nxt    = found_r || word_written;
  assign load_end     = in_load_last || (load_pos_r == LAST_K);
  assign changed      = (held_r != committed_r);
  assign wrap         = (ptr_r == FULL_P);
  assign pending_nxt  = pending_r || changed;

  // Select the memory write for load and append
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_pos_r;
    ram_wdata = in_word_value;
    if (accept) begin
      unique case (op)
        fpvl_pkg::OP_LOAD: begin
          ram_we = 1'b1;
          if (load_end && !found_nxt) begin
            ram_waddr = '0;
            ram_wdata = default_r;
          end
        end
        fpvl_pkg::OP_UPDATE: begin
          ram_we    = changed;
          ram_waddr = wrap ? '0 : ptr_r[AW-1:0];
          ram_wdata = held_r;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  fpvl_page_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_k_r),
    .rdata (ram_rdata)
  );

  // Hold the default value register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_r <= '0;
    end else if (cfg_we) begin
      default_r <= cfg_wdata;
    end
  end

  // Control, log state and the page sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ptr_r        <= '0;
      held_r       <= '0;
      committed_r  <= '0;
      pending_r    <= 1'b0;
      erase_r      <= 1'b0;
      load_pos_r   <= '0;
      found_r      <= 1'b0;
      rd_k_r       <= '0;
      emit_valid_r <= 1'b0;
    end else begin
      // Tag each sweep read for the emit stage
      emit_valid_r <= (state_r == ST_STREAM);
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (op)
              fpvl_pkg::OP_LOAD: begin
                if (word_written) begin
                  held_r      <= in_word_value;
                  committed_r <= in_word_value;
                  ptr_r       <= PW'(load_pos_r) + PW'(1);
                end
                if (load_end) begin
                  load_pos_r <= '0;
                  found_r    <= 1'b0;
                  if (!found_nxt) begin
                    held_r      <= default_r;
                    committed_r <= default_r;
                    ptr_r       <= PW'(1);
                    pending_r   <= 1'b1;
                    erase_r     <= 1'b0;
                  end
                end else begin
                  load_pos_r <= load_pos_r + AW'(1);
                  found_r    <= found_nxt;
                end
              end
              fpvl_pkg::OP_SET: begin
                held_r <= in_word_value;
              end
              fpvl_pkg::OP_UPDATE: begin
                if (changed) begin
                  committed_r <= held_r;
                  pending_r   <= 1'b1;
                  if (wrap) begin
                    ptr_r   <= PW'(1);
                    erase_r <= 1'b1;
                  end else begin
                    ptr_r <= ptr_r + PW'(1);
                  end
                end
                if (pending_nxt) begin
                  state_r <= ST_STREAM;
                  rd_k_r  <= '0;
                end
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_STREAM: begin
          // Issue one slot read per cycle
          if (rd_k_r == LAST_K) begin
            state_r   <= ST_IDLE;
            rd_k_r    <= '0;
            pending_r <= 1'b0;
            erase_r   <= 1'b0;
          end else begin
            rd_k_r <= rd_k_r + AW'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Emit stage payload
  always_ff @(posedge clk) begin
    emit_k_r     <= rd_k_r;
    emit_in_r    <= (PW'(rd_k_r) < ptr_r);
    emit_erase_r <= erase_r && (rd_k_r == '0);
    emit_last_r  <= (rd_k_r == LAST_K);
  end

  assign out_strobe        = emit_valid_r;
  assign out_erase_first   = emit_erase_r;
  assign out_slot_index    = fpvl_pkg::SLOT_INDEX_W'(emit_k_r);
  assign out_slot_data     = emit_in_r ? ram_rdata : fpvl_pkg::ERASED_WORD;
  assign out_current_value = held_r;
  assign out_last          = emit_last_r;

  // A page image runs without gaps until its last word
  a_image_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> out_strobe)
    else $error("page image broken before its last word");

  // A new image never follows directly on the last word
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> !out_strobe)
    else $error("word emitted right after the last word of an image");

  // Erase request only on slot zero
  a_erase_on_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_erase_first) |-> (out_slot_index == '0))
    else $error("erase flag on a slot other than the first");

  // A changed value always starts a page sweep
  a_change_commits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == fpvl_pkg::OP_UPDATE) && changed) |=> busy)
    else $error("changed value taken without a page sweep");

endmodule
